// ===== design/wbsm_pkg.sv =====
// Shared types, widths and codes for the wildcard byte signature matcher.
package wbsm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int POS_W       = 32;
    localparam int BYTE_W      = 8;

    localparam logic [POS_W-1:0] POS_SAT = '1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef byte_t [PATTERN_MAX-1:0] window_t;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_DATA    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    // Per-cell compare status handed back to the top level
    typedef struct packed {
        logic hit;
        logic fixed;
    } cell_stat_t;

endpackage

// ===== design/wbsm_item_if.sv =====
// Input item channel: load, data byte and restart transfers.
interface wbsm_item_if
    import wbsm_pkg::*;
;
    logic  valid;
    logic  ready;
    logic [1:0] mode;
    idx_t  entry_index;
    byte_t entry_value;
    logic  entry_wildcard;
    byte_t data_byte;

    modport source (output valid, mode, entry_index, entry_value, entry_wildcard, data_byte,
                    input ready);
    modport sink   (input valid, mode, entry_index, entry_value, entry_wildcard, data_byte,
                    output ready);
endinterface

// ===== design/wbsm_result_if.sv =====
// Result channel: one transfer per data byte.
interface wbsm_result_if
    import wbsm_pkg::*;
;
    logic valid;
    logic ready;
    logic match;
    pos_t match_offset;
    logic pattern_valid;

    modport source (output valid, match, match_offset, pattern_valid, input ready);
    modport sink   (input valid, match, match_offset, pattern_valid, output ready);
endinterface

// ===== design/wbsm_cfg_if.sv =====
// Configuration write channel for the pattern length register.
interface wbsm_cfg_if
    import wbsm_pkg::*;
;
    logic valid;
    logic ready;
    cnt_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/wbsm_cell.sv =====
// One matcher cell: a window byte stage and one pattern entry with its compare.
module wbsm_cell
    import wbsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  idx_t       cell_index,
    input  byte_t      shift_in,
    input  logic       shift_en,
    input  logic       clear,
    input  logic       load_en,
    input  idx_t       load_index,
    input  byte_t      load_value,
    input  logic       load_wild,
    input  window_t    window_next,
    input  idx_t       last_entry,
    output byte_t      win_byte,
    output cell_stat_t stat
);

    byte_t win_reg;
    byte_t value_reg;
    logic  wild_reg;
    idx_t  age;
    logic  in_use;
    logic  equal;

    // Window stage: take the neighbor's byte on each data transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (clear)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= shift_in;
        end
    end

    // Pattern entry, written only by a load addressed to this cell
    always_ff @(posedge clk)
    begin
        if (load_en && (load_index == cell_index))
        begin
            value_reg <= load_value;
            wild_reg  <= load_wild;
        end
    end

    // Entry k faces the byte of age (len-1-k) in the updated window
    always_comb
    begin
        in_use     = (cell_index <= last_entry);
        age        = last_entry - cell_index;
        equal      = (window_next[age] == value_reg);
        stat.hit   = !in_use || wild_reg || equal;
        stat.fixed = in_use && !wild_reg;
    end

    assign win_byte = win_reg;

endmodule

// ===== design/wildcard_byte_signature_matcher.sv =====
// Top level of the wildcard byte signature matcher: a row of matcher cells.
//
// Usage:
//   item   : valid/ready channel. mode 0 loads pattern entry entry_index with
//            entry_value / entry_wildcard, mode 1 feeds data_byte, mode 2
//            restarts the buffer (window, byte count and offset cleared).
//            mode 3 is dropped.
//   result : one transfer per data byte: match, match_offset (start of the
//            match in the buffer, saturating, 0 without a match) and
//            pattern_valid (some entry in use is fixed).
//   cfg    : valid/ready write of pattern_length (0 acts as 1, above 32 as
//            32); always ready. The user must write it while the block is
//            idle; the block itself does not enforce this.
// Throughput is one item per cycle: all 32 cells compare in parallel against
// the shifted window when the byte is taken; the result is registered and
// shows in the cycle after the transfer. Reset clears the window, counters
// and output valid and sets the length to 1; pattern entries hold no value
// until loaded. A stall holds the output and drops item.ready until it drains.
module wildcard_byte_signature_matcher
    import wbsm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    wbsm_item_if.sink     item,
    wbsm_result_if.source result,
    wbsm_cfg_if.sink      cfg
);

    cnt_t       len_reg;
    cnt_t       seen_reg;
    cnt_t       seen_next;
    pos_t       pos_reg;
    pos_t       pos_next;
    idx_t       last_entry;
    logic       item_fire;
    logic       load_fire;
    logic       data_fire;
    logic       restart_fire;
    window_t    window_next;
    byte_t      win_bytes [PATTERN_MAX];
    cell_stat_t stats [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit_vec;
    logic [PATTERN_MAX-1:0] fixed_vec;
    logic       hit;
    pos_t       offset;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       match_reg;
    pos_t       offset_reg;
    logic       pvalid_reg;

    // Handshakes
    assign item.ready = !out_valid_reg || result.ready;
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Mode decode
    always_comb
    begin
        load_fire    = 1'b0;
        data_fire    = 1'b0;
        restart_fire = 1'b0;
        unique case (item.mode)
            MODE_LOAD:    load_fire    = item_fire;
            MODE_DATA:    data_fire    = item_fire;
            MODE_RESTART: restart_fire = item_fire;
            default:      ;
        endcase
    end

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= CNT_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            len_reg <= cfg.data;
        end
    end

    // Index of the last entry in use, length clamped to 1..PATTERN_MAX
    always_comb
    begin
        if (len_reg == '0)
        begin
            last_entry = '0;
        end
        else if (len_reg > CNT_W'(PATTERN_MAX))
        begin
            last_entry = IDX_W'(PATTERN_MAX - 1);
        end
        else
        begin
            last_entry = IDX_W'(len_reg - CNT_W'(1));
        end
    end

    // Buffer counters
    assign seen_next = (seen_reg < CNT_W'(PATTERN_MAX)) ? seen_reg + CNT_W'(1) : seen_reg;
    assign pos_next  = (pos_reg != POS_SAT) ? pos_reg + POS_W'(1) : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (restart_fire)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (data_fire)
        begin
            seen_reg <= seen_next;
            pos_reg  <= pos_next;
        end
    end

    // Window as it stands after this byte: age 0 is the incoming byte
    always_comb
    begin
        window_next[0] = item.data_byte;
        for (int a = 1; a < PATTERN_MAX; a++)
        begin
            window_next[a] = win_bytes[a-1];
        end
    end

    // Row of cells
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        wbsm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_index  (IDX_W'(k)),
            .shift_in    (window_next[k]),
            .shift_en    (data_fire),
            .clear       (restart_fire),
            .load_en     (load_fire),
            .load_index  (item.entry_index),
            .load_value  (item.entry_value),
            .load_wild   (item.entry_wildcard),
            .window_next (window_next),
            .last_entry  (last_entry),
            .win_byte    (win_bytes[k]),
            .stat        (stats[k])
        );
        assign hit_vec[k]   = stats[k].hit;
        assign fixed_vec[k] = stats[k].fixed;
    end

    // Match decision and start offset
    assign hit    = (&hit_vec) && ({1'b0, last_entry} < seen_next);
    assign offset = !hit ? '0 :
                    (pos_reg == POS_SAT) ? POS_SAT :
                    pos_reg - POS_W'(last_entry);

    // Output register
    always_comb
    begin
        if (data_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_fire)
        begin
            match_reg  <= hit;
            offset_reg <= offset;
            pvalid_reg <= |fixed_vec;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.match         = match_reg;
    assign result.match_offset  = offset_reg;
    assign result.pattern_valid = pvalid_reg;

endmodule
